FILE: hw/rtl/chained_hash_map_assert.svh
// Assertion macros for the chained hash map RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CHAINED_HASH_MAP_ASSERT_SVH
`define CHAINED_HASH_MAP_ASSERT_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CHM_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CHM_ASSERT(label, clk, rst_n, prop, msg)
`define CHM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/chm_pkg.sv
// Shared types and constants for the chained hash map.
// No dependencies.
`default_nettype none
package chm_pkg;
  localparam int unsigned Buckets = 256;
  localparam int unsigned PoolEntries = 512;
  localparam int unsigned BktW = $clog2(Buckets);
  localparam int unsigned IdxW = $clog2(PoolEntries);
  localparam int unsigned LnkW = IdxW + 1;
  localparam int unsigned CntW = $clog2(PoolEntries + 1);

  localparam logic [1:0] CmdSet = 2'd0;
  localparam logic [1:0] CmdGet = 2'd1;
  localparam logic [1:0] CmdDel = 2'd2;
  localparam logic [1:0] CmdRsvd = 2'd3;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StMissing = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StRsvd = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic signed [31:0] key;
    logic [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] read_value;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, start head read
    logic read_ent;  // read the entry at cur
    logic step;      // advance cur to link
    logic rd_free;   // read top free slot
    logic wr_val;    // overwrite value of hit
    logic ins_ent;   // write new entry
    logic ins_link;  // link new entry behind last or at head
    logic unlink;    // unlink hit
    logic push_free; // return hit to pool
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic cur_valid; // cur is an entry
    logic key_match;
    logic walk_done; // step limit reached
    logic pool_full;
    logic cnt_nz;
  } sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/chm_datapath.sv
// Datapath of the chained hash map: bucket heads, entry pool, free stack.
// Depends on chm_pkg.
`default_nettype none
module chm_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire chm_pkg::req_t  req_i,
  input  wire chm_pkg::cmd_t  cmd_i,
  output chm_pkg::sts_t       sts_o,
  output logic [31:0]         value_o
);
  localparam logic [chm_pkg::LnkW-1:0] NoEntry = chm_pkg::LnkW'(chm_pkg::PoolEntries);

  // memories
  logic [chm_pkg::LnkW-1:0] heads_mem [chm_pkg::Buckets];
  logic [chm_pkg::Buckets-1:0] head_vld_q;
  logic [31:0] keys_mem [chm_pkg::PoolEntries];
  logic [31:0] vals_mem [chm_pkg::PoolEntries];
  logic [chm_pkg::LnkW-1:0] links_mem [chm_pkg::PoolEntries];
  logic [chm_pkg::IdxW-1:0] free_mem [chm_pkg::PoolEntries];

  chm_pkg::req_t req_q;
  logic [chm_pkg::BktW-1:0] bkt;
  logic [chm_pkg::LnkW-1:0] cur_q, prev_q, head_rd_q, link_rd_q;
  logic [31:0] key_rd_q, val_rd_q;
  logic [chm_pkg::IdxW-1:0] free_rd_q;
  logic free_rd_vld_q, head_rd_vld_q, use_head_q;
  logic [chm_pkg::CntW-1:0] cnt_q, steps_q, hw_q;
  logic [chm_pkg::IdxW-1:0] top_idx;
  logic [chm_pkg::LnkW-1:0] cur_eff;
  logic [chm_pkg::IdxW-1:0] slot;

  assign bkt = req_q.key[chm_pkg::BktW-1:0];
  assign top_idx = chm_pkg::IdxW'(chm_pkg::CntW'(chm_pkg::PoolEntries) - cnt_q - 1'b1);
  // cur after a load comes from the head read
  assign cur_eff = use_head_q ? (head_rd_vld_q ? head_rd_q : NoEntry) : cur_q;
  // free stack slots above the high-water mark are read as their own index
  assign slot = free_rd_vld_q ? free_rd_q : top_idx;

  // capture request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  // head memory, valid bits cleared by reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) head_rd_q <= heads_mem[req_i.key[chm_pkg::BktW-1:0]];
    if (cmd_i.ins_link && prev_q == NoEntry)
      heads_mem[bkt] <= {1'b0, slot};
    else if (cmd_i.unlink && prev_q == NoEntry)
      heads_mem[bkt] <= link_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      head_rd_vld_q <= 1'b0;
      use_head_q <= 1'b0;
      cur_q <= NoEntry;
      prev_q <= NoEntry;
      steps_q <= '0;
      cnt_q <= '0;
      hw_q <= '0;
      free_rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        head_rd_vld_q <= head_vld_q[req_i.key[chm_pkg::BktW-1:0]];
        use_head_q <= 1'b1;
        prev_q <= NoEntry;
        steps_q <= '0;
      end else if (cmd_i.read_ent) begin
        use_head_q <= 1'b0;
        cur_q <= cur_eff;
      end else if (cmd_i.step) begin
        prev_q <= cur_q;
        cur_q <= link_rd_q;
        steps_q <= steps_q + 1'b1;
      end
      if ((cmd_i.ins_link || cmd_i.unlink) && prev_q == NoEntry)
        head_vld_q[bkt] <= 1'b1;
      if (cmd_i.rd_free) free_rd_vld_q <= cnt_q < hw_q;
      if (cmd_i.ins_link) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == hw_q) hw_q <= hw_q + 1'b1;
      end
      if (cmd_i.push_free) cnt_q <= cnt_q - 1'b1;
    end
  end

  // entry memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_ent) begin
      key_rd_q <= keys_mem[cur_eff[chm_pkg::IdxW-1:0]];
      val_rd_q <= vals_mem[cur_eff[chm_pkg::IdxW-1:0]];
      link_rd_q <= links_mem[cur_eff[chm_pkg::IdxW-1:0]];
    end
    if (cmd_i.wr_val) vals_mem[cur_q[chm_pkg::IdxW-1:0]] <= req_q.new_value;
    if (cmd_i.ins_ent) begin
      keys_mem[slot] <= req_q.key;
      vals_mem[slot] <= req_q.new_value;
    end
    if (cmd_i.ins_ent) links_mem[slot] <= NoEntry;
    else if (cmd_i.ins_link && prev_q != NoEntry)
      links_mem[prev_q[chm_pkg::IdxW-1:0]] <= {1'b0, slot};
    else if (cmd_i.unlink && prev_q != NoEntry)
      links_mem[prev_q[chm_pkg::IdxW-1:0]] <= link_rd_q;
  end

  // free stack; untouched entries are taken as their own index
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_free) free_rd_q <= free_mem[top_idx];
    if (cmd_i.push_free)
      free_mem[chm_pkg::IdxW'(chm_pkg::CntW'(chm_pkg::PoolEntries) - cnt_q)] <= cur_q[chm_pkg::IdxW-1:0];
  end

  assign sts_o.command = req_q.command;
  assign sts_o.cur_valid = (cur_eff < NoEntry) && !sts_o.walk_done;
  assign sts_o.key_match = key_rd_q == req_q.key;
  assign sts_o.walk_done = steps_q >= chm_pkg::CntW'(chm_pkg::PoolEntries);
  assign sts_o.pool_full = cnt_q >= chm_pkg::CntW'(chm_pkg::PoolEntries);
  assign sts_o.cnt_nz = cnt_q != '0;
  assign value_o = val_rd_q;
endmodule
`default_nettype wire

FILE: hw/rtl/chm_ctrl.sv
// Controller of the chained hash map: sequences the chain walk and updates.
// Depends on chm_pkg and chained_hash_map_assert.svh.
`default_nettype none
`include "chained_hash_map_assert.svh"
module chm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire chm_pkg::sts_t  sts_i,
  input  wire logic [31:0]    value_i,
  output chm_pkg::cmd_t       cmd_o,
  output chm_pkg::rsp_t       rsp_o
);
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SCmp   = 3'd2;
  localparam logic [2:0] SFree  = 3'd3;
  localparam logic [2:0] SIns   = 3'd4;
  localparam logic [2:0] SLink  = 3'd5;
  localparam logic [2:0] SResp  = 3'd6;

  logic [2:0] state_q, state_d;
  chm_pkg::rsp_t rsp_q, rsp_d;
  logic vld_q, vld_d;
  logic in_fire;

  assign in_fire = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != SIdle) || vld_q;

  always_comb begin
    state_d = state_q;
    rsp_d = rsp_q;
    vld_d = vld_q && out_stall_i;
    cmd_o = '0;
    case (state_q)
      SIdle: begin
        if (in_fire) begin
          cmd_o.load = 1'b1;
          state_d = SRead;
        end
      end
      SRead: begin
        // read entry at cur, or finish the walk without a hit
        if (sts_i.cur_valid) begin
          cmd_o.read_ent = 1'b1;
          state_d = SCmp;
        end else if (sts_i.command == chm_pkg::CmdSet && !sts_i.pool_full) begin
          cmd_o.rd_free = 1'b1;
          state_d = SIns;
        end else begin
          rsp_d.status = (sts_i.command == chm_pkg::CmdSet) ? chm_pkg::StFull
                                                            : chm_pkg::StMissing;
          rsp_d.read_value = '0;
          state_d = SResp;
        end
      end
      SCmp: begin
        if (sts_i.key_match && sts_i.command != chm_pkg::CmdRsvd) begin
          rsp_d.status = chm_pkg::StOk;
          rsp_d.read_value = (sts_i.command == chm_pkg::CmdGet) ? value_i : '0;
          cmd_o.wr_val = sts_i.command == chm_pkg::CmdSet;
          cmd_o.unlink = sts_i.command == chm_pkg::CmdDel;
          cmd_o.push_free = (sts_i.command == chm_pkg::CmdDel) && sts_i.cnt_nz;
          state_d = SResp;
        end else begin
          cmd_o.step = 1'b1;
          state_d = SRead;
        end
      end
      SIns: begin
        cmd_o.ins_ent = 1'b1;
        state_d = SLink;
      end
      SLink: begin
        cmd_o.ins_link = 1'b1;
        rsp_d.status = chm_pkg::StOk;
        rsp_d.read_value = '0;
        state_d = SResp;
      end
      SResp: begin
        vld_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = vld_q;
  assign rsp_o = rsp_q;

  `CHM_ASSERT(a_no_accept_busy, clk_i, rst_ni, in_fire |-> state_q == SIdle && !vld_q, "accept while busy")
  `CHM_ASSERT(a_one_word, clk_i, rst_ni, (state_q == SResp) |=> out_valid_o, "result word lost")
  `CHM_ASSERT(a_status_range, clk_i, rst_ni, out_valid_o |-> rsp_o.status != chm_pkg::StRsvd, "bad status")
endmodule
`default_nettype wire

FILE: hw/rtl/chained_hash_map.sv
// Top level of the chained hash map: controller plus datapath.
// Depends on chm_pkg, chm_ctrl, chm_datapath.
//   channel  dir  payload          handshake
//   request  in   req_i  (req_t)   req_valid_i / req_stall_o
//   result   out  rsp_o  (rsp_t)   rsp_valid_o / rsp_stall_i
// One request at a time: the result word follows a hit on a chain entry, or a
// walk without a hit, or for an insert the SIns and SLink states after that;
// each entry costs a read state (SRead) and a compare state (SCmp).
// The next request is taken the cycle after the result word is taken.
// Bucket heads carry valid bits cleared by reset and the free stack a
// high-water mark; no clearing pass. A waiting result word blocks the input.
`default_nettype none
module chained_hash_map (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_stall_o,
  input  wire chm_pkg::req_t  req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_stall_i,
  output chm_pkg::rsp_t       rsp_o
);
  chm_pkg::cmd_t cmd;
  chm_pkg::sts_t sts;
  logic [31:0] value;

  chm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req_valid_i), .in_stall_o(req_stall_o),
    .out_valid_o(rsp_valid_o), .out_stall_i(rsp_stall_i),
    .sts_i(sts), .value_i(value), .cmd_o(cmd), .rsp_o(rsp_o)
  );

  chm_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .value_o(value)
  );
endmodule
`default_nettype wire
